[hdl/ppe_pkg.sv]
`default_nettype none
package ppe_pkg;

  localparam int QW    = 32;
  localparam int LW    = 16;
  localparam int IDXW  = 6;
  localparam int RANKW = 6;
  localparam int NUMW  = 48;
  localparam int PRODW = 50;

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    q_t px, py, pz;
    q_t vx, vy, vz;
    q_t ax, ay, az;
    q_t sb, se;
    logic [LW-1:0] life;
    logic [LW-1:0] frame;
  } part_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_UP,
    SH_DOWN
  } shift_t;

  typedef struct packed {
    shift_t op;
    logic wr_en;
    logic [IDXW-1:0] wr_idx;
  } cell_ctl_t;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  function automatic q_t sat_add(input q_t a, input q_t b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end
    return s[QW-1:0];
  endfunction

endpackage
`default_nettype wire

[hdl/ppe_in_if.sv]
`default_nettype none
interface ppe_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic [15:0] life_frames;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [31:0] vel_x, vel_y, vel_z;
  logic signed [31:0] acc_x, acc_y, acc_z;
  logic signed [63:0] scale_begin_end;

  modport source (output valid, mode, life_frames, pos_x, pos_y, pos_z, vel_x, vel_y,
                  vel_z, acc_x, acc_y, acc_z, scale_begin_end, input ready);
  modport sink (input valid, mode, life_frames, pos_x, pos_y, pos_z, vel_x, vel_y,
                vel_z, acc_x, acc_y, acc_z, scale_begin_end, output ready);
endinterface
`default_nettype wire

[hdl/ppe_out_if.sv]
`default_nettype none
interface ppe_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_scale;
  logic [5:0] rank;
  logic last;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_scale, rank, last,
                  input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_scale, rank, last,
                output ready);
endinterface
`default_nettype wire

[hdl/ppe_cell.sv]
`default_nettype none
module ppe_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  ppe_pkg::cell_ctl_t ctl,
  input  ppe_pkg::part_t    wdata,
  input  ppe_pkg::part_t    up_d,
  input  ppe_pkg::part_t    down_d,
  output ppe_pkg::part_t    q
);
  import ppe_pkg::*;

  logic hit;
  assign hit = ctl.wr_en && (ctl.wr_idx == IDXW'(IDX));

  always_ff @(posedge clk) begin
    if (hit) begin
      q <= wdata;
    end else begin
      unique case (ctl.op)
        SH_HOLD: q <= q;
        SH_UP:   q <= up_d;
        SH_DOWN: q <= down_d;
        default: q <= q;
      endcase
    end
  end
endmodule
`default_nettype wire

[hdl/ppe_div.sv]
`default_nettype none
module ppe_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppe_pkg::NUMW-1:0]      num,
  input  logic [ppe_pkg::LW-1:0]        den,
  output logic                          done,
  output logic [ppe_pkg::NUMW-1:0]      quo
);
  import ppe_pkg::*;

  localparam int CNTW = $clog2(NUMW + 1);

  logic [LW:0]      rem;
  logic [LW-1:0]    dreg;
  logic [CNTW-1:0]  left;
  logic             busy;
  logic [LW:0]      trial;
  logic             take;

  // one quotient bit per cycle, restoring
  assign trial = {rem[LW-1:0], quo[NUMW-1]};
  assign take  = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= CNTW'(NUMW);
        rem  <= '0;
        dreg <= den;
        quo  <= num;
      end else if (busy) begin
        rem  <= take ? (trial - {1'b0, dreg}) : trial;
        quo  <= {quo[NUMW-2:0], take};
        left <= left - 1'b1;
        if (left == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[hdl/particle_pool_euler_update_unit.sv]
// Particle pool with per-frame Euler integration.
// feed (sink): mode 0 stores a new particle at the head of the pool, mode 1
// ticks the pool. result (source): one item per live particle on a tick,
// newest first, rank counting up, last set on the final one.
// An add to a full pool is dropped. A tick runs two passes over the cell
// chain: it first visits each stored particle to retire expired ones and integrate
// the rest, then per live particle runs a multiply, a divider start, a serial
// divide of 48 quotient bits until the divider finishes, and an emit step.
// A tick holds the input until its last result has been emitted. An empty pool,
// or one where all particles expire, gives no result.
// feed.ready is high only between ticks. A finished result sits in the output
// register; if the receiver stalls, the emit step waits for it.
// Reset clears the particle count and the handshake state; cell contents are
// left as they are and never read before an add writes them.
`default_nettype none
module particle_pool_euler_update_unit #(
  parameter int POOL_DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  ppe_in_if.sink    feed,
  ppe_out_if.source result
);
  import ppe_pkg::*;

  localparam int CW = $clog2(POOL_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS1,
    ST_MUL,
    ST_DIVS,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;
  logic [CW-1:0] cnt, k, d;

  part_t cq [POOL_DEPTH];
  part_t head, wdata, integ, newp;
  cell_ctl_t ctl;

  logic signed [PRODW-1:0] prod;
  logic neg;
  logic [NUMW-1:0] mag, quo;
  logic div_start, div_done;

  logic expired, last_step, emit_go;
  logic [CW-1:0] tail, cnt_left;
  logic signed [QW:0] diff;
  logic signed [33:0] qv, qs, ssum;

  assign head = cq[0];

  genvar gi;
  generate
    for (gi = 0; gi < POOL_DEPTH; gi++) begin : g_cell
      ppe_cell #(.IDX(gi)) u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .wdata (wdata),
        .up_d  ((gi == 0) ? wdata : cq[(gi == 0) ? 0 : gi - 1]),
        .down_d(cq[(gi == POOL_DEPTH - 1) ? gi : gi + 1]),
        .q     (cq[gi])
      );
    end
  endgenerate

  always_comb begin
    newp.px    = feed.pos_x;
    newp.py    = feed.pos_y;
    newp.pz    = feed.pos_z;
    newp.vx    = feed.vel_x;
    newp.vy    = feed.vel_y;
    newp.vz    = feed.vel_z;
    newp.ax    = feed.acc_x;
    newp.ay    = feed.acc_y;
    newp.az    = feed.acc_z;
    newp.sb    = feed.scale_begin_end[63:32];
    newp.se    = feed.scale_begin_end[31:0];
    newp.life  = feed.life_frames;
    newp.frame = '0;
  end

  always_comb begin
    integ       = head;
    integ.frame = head.frame + 1'b1;
    integ.vx    = sat_add(head.vx, head.ax);
    integ.vy    = sat_add(head.vy, head.ay);
    integ.vz    = sat_add(head.vz, head.az);
    integ.px    = sat_add(head.px, integ.vx);
    integ.py    = sat_add(head.py, integ.vy);
    integ.pz    = sat_add(head.pz, integ.vz);
  end

  assign expired   = head.frame >= head.life;
  assign last_step = (k == cnt - 1'b1);
  assign cnt_left  = cnt - d - CW'(expired);
  assign emit_go   = !result.valid || result.ready;
  // kept particles are appended behind the unprocessed ones
  assign tail      = cnt - 1'b1 - ((state == ST_PASS1) ? d : '0);

  always_comb begin
    ctl.op     = SH_HOLD;
    ctl.wr_en  = 1'b0;
    ctl.wr_idx = IDXW'(tail);
    wdata      = head;
    unique case (state)
      ST_IDLE: begin
        wdata      = newp;
        ctl.wr_idx = '0;
        if (feed.valid && feed.mode == MODE_ADD && cnt < CW'(POOL_DEPTH)) begin
          ctl.op    = SH_UP;
          ctl.wr_en = 1'b1;
        end
      end
      ST_PASS1: begin
        wdata     = integ;
        ctl.op    = SH_DOWN;
        ctl.wr_en = !expired;
      end
      ST_EMIT: begin
        if (emit_go) begin
          ctl.op    = SH_DOWN;
          ctl.wr_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign diff      = {head.se[QW-1], head.se} - {head.sb[QW-1], head.sb};
  assign mag       = prod[PRODW-1] ? NUMW'(-prod) : NUMW'(prod);
  assign div_start = (state == ST_DIVS);
  assign qv        = {1'b0, quo[32:0]};
  assign qs        = neg ? -qv : qv;
  assign ssum      = {{2{head.sb[QW-1]}}, head.sb} + qs;

  ppe_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (mag),
    .den  (head.life),
    .done (div_done),
    .quo  (quo)
  );

  assign feed.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      k            <= '0;
      d            <= '0;
      result.valid <= 1'b0;
    end else begin
      if (state == ST_EMIT && emit_go) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (feed.valid) begin
            if (feed.mode == MODE_ADD) begin
              if (cnt < CW'(POOL_DEPTH)) begin
                cnt <= cnt + 1'b1;
              end
            end else if (cnt != '0) begin
              k     <= '0;
              d     <= '0;
              state <= ST_PASS1;
            end
          end
        end
        ST_PASS1: begin
          d <= d + CW'(expired);
          if (last_step) begin
            cnt <= cnt_left;
            k   <= '0;
            state <= (cnt_left == '0) ? ST_IDLE : ST_MUL;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_MUL: begin
          prod  <= diff * $signed({1'b0, head.frame});
          state <= ST_DIVS;
        end
        ST_DIVS: begin
          neg   <= prod[PRODW-1];
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            result.out_pos_x <= head.px;
            result.out_pos_y <= head.py;
            result.out_pos_z <= head.pz;
            result.out_scale <= ssum[QW-1:0];
            result.rank      <= RANKW'(k);
            result.last      <= last_step;
            k                <= k + 1'b1;
            state            <= last_step ? ST_IDLE : ST_MUL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(POOL_DEPTH)) else $error("particle count beyond pool depth");

  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (feed.valid && feed.ready && feed.mode == MODE_ADD && cnt < CW'(POOL_DEPTH))
    |=> cnt == $past(cnt) + 1'b1) else $error("accepted add did not grow pool");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV) else $error("divider finished outside divide step");
`endif

endmodule
`default_nettype wire
